[sv/avg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_pkg
// shared types, widths and fixed-point helpers for the arc vertex generator
// ----------------------------------------------------------------------------
package avg_pkg;

  localparam int COORD_W        = 24;
  localparam int TAN_W          = 18;
  localparam int COS_W          = 17;
  localparam int SEG_W          = 7;
  localparam int FRAC_SHIFT     = 16;
  localparam int PROD_W         = COORD_W + TAN_W;   // q16.8 x q1.16, cos widened to signed
  localparam int SHIFTED_W      = PROD_W - FRAC_SHIFT;
  localparam int WIDE_W         = SHIFTED_W + 2;     // headroom for add / subtract
  localparam int QUEUE_DEPTH    = 2;                 // power of two, pointers wrap
  localparam int MAX_SEGMENTS_D = 64;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [TAN_W-1:0]     tan_t;
  typedef logic        [COS_W-1:0]     cos_t;
  typedef logic        [SEG_W-1:0]     seg_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SHIFTED_W-1:0] shifted_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;

  // one classified arc waiting in the queue
  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t start_x;
    coord_t start_y;
    tan_t   tan_factor;
    cos_t   cos_factor;
    seg_t   count;
  } arc_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    arc_item_t item;
  } avg_queue_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EMIT,
    BK_MUL_TAN,
    BK_SUM,
    BK_MUL_COS,
    BK_SCALE
  } avg_back_state_t;

  // arithmetic shift of a product by the fraction width, rounds toward minus infinity
  function automatic shifted_t floor_q16(input prod_t p);
    floor_q16 = p[PROD_W-1:FRAC_SHIFT];
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'(COORD_MAX);
    lo = wide_t'(COORD_MIN);
    if (v > hi) begin
      sat_coord = COORD_MAX;
    end else if (v < lo) begin
      sat_coord = COORD_MIN;
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

[sv/avg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_front
// accepts arc commands, clamps the segment count, drops empty arcs and
// buffers the rest in a short queue for the back end
// ----------------------------------------------------------------------------
module avg_front
  import avg_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  coord_t     in_center_x,
  input  coord_t     in_center_y,
  input  coord_t     in_start_x,
  input  coord_t     in_start_y,
  input  tan_t       in_tan_factor,
  input  cos_t       in_cos_factor,
  input  seg_t       in_segment_count,
  output avg_queue_t q_head,
  input  logic       q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  arc_item_t          q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               full;
  logic               accept;
  logic               push;
  logic               pop;
  seg_t               seg_clamped;
  arc_item_t          new_item;

  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign busy   = full;
  assign accept = start && !busy;

  // counts above the limit clamp, zero counts produce nothing
  always_comb begin
    if (32'(in_segment_count) > MAX_SEGMENTS) begin
      seg_clamped = SEG_W'(MAX_SEGMENTS);
    end else begin
      seg_clamped = in_segment_count;
    end
  end

  assign push = accept && (in_segment_count != '0);
  assign pop  = q_pop && (cnt_r != '0);

  always_comb begin
    new_item.center_x   = in_center_x;
    new_item.center_y   = in_center_y;
    new_item.start_x    = in_start_x;
    new_item.start_y    = in_start_y;
    new_item.tan_factor = in_tan_factor;
    new_item.cos_factor = in_cos_factor;
    new_item.count      = seg_clamped;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = q_mem[rd_ptr_r];

  // occupancy never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // a push into a full queue cannot happen
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  // occupancy tracks push and pop
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not follow push");

endmodule

[sv/avg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_back
// walks one arc at a time: emits centre plus point, then rotates the point
// with the tangential and radial factors over four multiply/add steps
// ----------------------------------------------------------------------------
module avg_back
  import avg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  avg_queue_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  output coord_t     out_vertex_x,
  output coord_t     out_vertex_y,
  output logic       out_last_vertex
);

  avg_back_state_t state_r, state_nxt;

  seg_t   rem_r, rem_nxt;
  coord_t cx_r, cx_nxt;
  coord_t cy_r, cy_nxt;
  coord_t px_r, px_nxt;
  coord_t py_r, py_nxt;
  tan_t   tan_r, tan_nxt;
  cos_t   cos_r, cos_nxt;
  coord_t sx_r, sx_nxt;
  coord_t sy_r, sy_nxt;
  prod_t  pa_r, pa_nxt;
  prod_t  pb_r, pb_nxt;

  logic   valid_r, valid_nxt;
  logic   last_r, last_nxt;
  coord_t vx_r, vx_nxt;
  coord_t vy_r, vy_nxt;

  logic signed [COS_W:0] cos_s;
  wide_t  w_px, w_py, w_cx, w_cy, w_sa, w_sb;

  assign cos_s = {1'b0, cos_r};

  always_comb begin
    w_px = wide_t'(px_r);
    w_py = wide_t'(py_r);
    w_cx = wide_t'(cx_r);
    w_cy = wide_t'(cy_r);
    w_sa = wide_t'(floor_q16(pa_r));
    w_sb = wide_t'(floor_q16(pb_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:    if (q_head.valid) state_nxt = BK_EMIT;
      BK_EMIT:    state_nxt = (rem_r == SEG_W'(1)) ? BK_IDLE : BK_MUL_TAN;
      BK_MUL_TAN: state_nxt = BK_SUM;
      BK_SUM:     state_nxt = BK_MUL_COS;
      BK_MUL_COS: state_nxt = BK_SCALE;
      BK_SCALE:   state_nxt = BK_EMIT;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop     = 1'b0;
    rem_nxt   = rem_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    tan_nxt   = tan_r;
    cos_nxt   = cos_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    valid_nxt = 1'b0;
    last_nxt  = 1'b0;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          q_pop   = 1'b1;
          cx_nxt  = q_head.item.center_x;
          cy_nxt  = q_head.item.center_y;
          px_nxt  = q_head.item.start_x;
          py_nxt  = q_head.item.start_y;
          tan_nxt = q_head.item.tan_factor;
          cos_nxt = q_head.item.cos_factor;
          rem_nxt = q_head.item.count;
        end
      end
      BK_EMIT: begin
        valid_nxt = 1'b1;
        last_nxt  = (rem_r == SEG_W'(1));
        vx_nxt    = sat_coord(w_cx + w_px);
        vy_nxt    = sat_coord(w_cy + w_py);
        rem_nxt   = rem_r - SEG_W'(1);
      end
      BK_MUL_TAN: begin
        pa_nxt = prod_t'(py_r) * prod_t'(tan_r);
        pb_nxt = prod_t'(px_r) * prod_t'(tan_r);
      end
      BK_SUM: begin
        sx_nxt = sat_coord(w_px - w_sa);
        sy_nxt = sat_coord(w_py + w_sb);
      end
      BK_MUL_COS: begin
        pa_nxt = prod_t'(sx_r) * prod_t'(cos_s);
        pb_nxt = prod_t'(sy_r) * prod_t'(cos_s);
      end
      BK_SCALE: begin
        px_nxt = sat_coord(w_sa);
        py_nxt = sat_coord(w_sb);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      rem_r   <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    tan_r <= tan_nxt;
    cos_r <= cos_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    vx_r  <= vx_nxt;
    vy_r  <= vy_nxt;
  end

  assign out_valid       = valid_r;
  assign out_vertex_x    = vx_r;
  assign out_vertex_y    = vy_r;
  assign out_last_vertex = last_r;

  // a strobe only follows an emit step
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == BK_EMIT))
    else $error("vertex strobe without emit step");

  // an emit step always has a vertex left
  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (rem_r != '0))
    else $error("emit with no vertex remaining");

  // the last vertex of an arc returns the engine to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |-> (state_r == BK_IDLE))
    else $error("engine still running after last vertex");

  // a new arc is taken only once the previous one has finished
  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (rem_r == '0))
    else $error("arc popped while vertices remain");

endmodule

[sv/arc_vertex_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_vertex_generator_top
// arc tessellator: turns one arc command into a run of rotated vertices
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low.
// Each arc carries a centre, a start point relative to the centre, a step
// rotation given as tan and cos of the step angle, and a segment count
// (clamped to MAX_SEGMENTS, a count of zero yields no vertex). The block emits
// one vertex per segment, centre plus current point, saturated Q16.8, each on
// the out_ ports for a single cycle with out_valid high; out_last_vertex marks
// the final vertex of the arc. The receiver cannot stall the block, so every
// strobe must be captured when it appears. When the engine is free, the first
// vertex of an arc passes through the command queue, the idle pop and the
// emit step; each further vertex waits for the rotation step (two multiply
// stages and two add/saturate stages on the one point register). A two-entry
// command queue lets up to two further arcs be taken while one is being drawn;
// busy is high while that queue is full.
// ----------------------------------------------------------------------------
module arc_vertex_generator_top
  import avg_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_D
) (
  input  logic   clk,
  input  logic   rst_n,

  // command channel
  input  logic   start,
  output logic   busy,
  input  coord_t in_center_x,
  input  coord_t in_center_y,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  tan_t   in_tan_factor,
  input  cos_t   in_cos_factor,
  input  seg_t   in_segment_count,

  // vertex channel, one transfer per strobe
  output logic   out_valid,
  output coord_t out_vertex_x,
  output coord_t out_vertex_y,
  output logic   out_last_vertex
);

  // queue head and pop between the two halves
  avg_queue_t q_head;
  logic       q_pop;

  // front end: command capture, count clamp, empty-arc filter, queue
  avg_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_tan_factor    (in_tan_factor),
    .in_cos_factor    (in_cos_factor),
    .in_segment_count (in_segment_count),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  // back end: vertex emission and point rotation
  avg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_last_vertex (out_last_vertex)
  );

endmodule
